[hw/rtl/field_diffusion_decay_stencil_unit_defines.svh]
// Assertion macros used by the port checker of the stencil unit.
// Depends on nothing; included by bare file name.
`ifndef FIELD_DIFFUSION_DECAY_STENCIL_UNIT_DEFINES_SVH
`define FIELD_DIFFUSION_DECAY_STENCIL_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define FDDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil unit port check failed");

// Next-cycle implication, off while reset is asserted.
`define FDDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil unit port check failed");

// Next-cycle implication that also holds through reset.
`define FDDS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("stencil unit port check failed");

`endif

[hw/rtl/fdds_pkg.sv]
// Shared types and constants of the field diffusion/decay stencil unit.
// Depends on nothing; used by the top level and its port checker.
`timescale 1ns / 1ps

package fdds_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_MUL,
        ST_ADD,
        ST_SCALE
    } state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_DECAY_PROB   = 2'd2;
    localparam logic [1:0] CFG_DIFFUSE_PROB = 2'd3;

    // Input commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Cell kinds; the unused codes behave as a free cell
    localparam logic [1:0] KIND_MOVABLE   = 2'd1;
    localparam logic [1:0] KIND_IMMOVABLE = 2'd2;

    // Field widths
    localparam int VALUE_W  = 16;
    localparam int KIND_W   = 2;
    localparam int HEIGHT_W = 11;
    localparam int ROW_W    = 10;
    localparam int PROB_W   = 17;
    localparam int SUM_W    = 19;
    localparam int TAP_W    = 4;

    localparam logic [PROB_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 11'd1024;
    localparam logic [TAP_W-1:0]    LAST_TAP   = 4'd8;

    // Edges from an emitting input beat to the first sample of its result
    localparam int RESULT_LATENCY = 14;

endpackage

[hw/rtl/field_diffusion_decay_stencil_unit.sv]
// Top level of the field diffusion/decay stencil unit: line store, sequencer, arithmetic.
// Depends on fdds_pkg.
`timescale 1ns / 1ps

// Usage
//   Input beats (s_*) carry grid cells in raster order (s_tuser = push) or flush
//   beats (s_tuser = flush). Result beats (m_*) carry the updated cell values in
//   raster order, m_tlast marking the final cell of the grid. The result of a cell
//   is released by the push that comes width+1 cells after it in raster order;
//   once the whole grid is in, each flush beat releases one more result.
//   Geometry and probabilities are written through the cfg_* port, by the user only
//   while idle (the block does not enforce this); writing width or height restarts the grid.
//   Input flow: a beat that releases no result leaves s_tready high. A beat that
//   releases a result holds s_tready low until its result is in the output register:
//   nine reads of the 3x3 window through the single read port of the line store, then
//   four arithmetic steps.
//   The output register decouples the sides: inputs are still taken while a
//   result waits; only a second result stalls until m_tready takes the first.
//   Reset (aresetn low, synchronous) restores 16x16 geometry and zero
//   probabilities, empties the grid and drops any pending result. The line store
//   itself is not cleared; only entries written in the current grid are used.
//   Writes and reads never overlap in time: a cell is written on its input beat,
//   and the window reads start only after that edge.
module field_diffusion_decay_stencil_unit #(
    parameter int MAX_WIDTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] cell_value, [17:16] cell_type, [23:18] zero
    input  logic        s_tuser,   // [0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] new_value
    output logic        m_tlast,   // is_last
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int DEPTH = 2 * MAX_WIDTH + 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = (WW > 9) ? WW : 9;
    localparam int PW    = $clog2(MAX_WIDTH + 3);
    localparam int MW    = fdds_pkg::VALUE_W + fdds_pkg::KIND_W;

    // Line store
    logic [MW-1:0] mem [DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // Configuration
    logic [8:0]                     grid_width_reg, grid_width_next;
    logic [fdds_pkg::HEIGHT_W-1:0]  grid_height_reg, grid_height_next;
    logic [fdds_pkg::PROB_W-1:0]    decay_reg, decay_next;
    logic [fdds_pkg::PROB_W-1:0]    diffuse_reg, diffuse_next;

    // Positions and pointers
    logic [WW-1:0]                  in_col_reg, in_col_next;
    logic [fdds_pkg::HEIGHT_W-1:0]  in_row_reg, in_row_next;
    logic [WW-1:0]                  out_col_reg, out_col_next;
    logic [fdds_pkg::ROW_W-1:0]     out_row_reg, out_row_next;
    logic [PW-1:0]                  pend_reg, pend_next;
    logic [AW-1:0]                  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]                  out_ptr_reg, out_ptr_next;

    // Sequencer
    fdds_pkg::state_t               state_reg, state_next;
    logic [fdds_pkg::TAP_W-1:0]     tap_reg, tap_next;
    logic                           pipe_valid_reg, pipe_valid_next;
    logic [fdds_pkg::TAP_W-1:0]     pipe_tap_reg, pipe_tap_next;
    logic [AW-1:0]                  cen_ptr_reg, cen_ptr_next;
    logic [7:0]                     nb_ok_reg, nb_ok_next;
    logic                           last_reg, last_next;

    // Arithmetic
    logic [fdds_pkg::VALUE_W-1:0]   v_reg, v_next;
    logic [fdds_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [fdds_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [fdds_pkg::PROB_W-1:0]    a_reg, a_next;
    logic [fdds_pkg::PROB_W-1:0]    b_reg, b_next;
    logic [fdds_pkg::PROB_W:0]      ab_reg, ab_next;

    // Output register
    logic                           m_valid_reg, m_valid_next;
    logic [fdds_pkg::VALUE_W-1:0]   m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    // Derived values
    logic [XW-1:0]                  gw_x;
    logic [WW-1:0]                  eff_w, w_m1;
    logic [fdds_pkg::HEIGHT_W-1:0]  eff_h, h_m1;
    logic [fdds_pkg::PROB_W-1:0]    eff_d, eff_f, keep, omf;
    logic [32:0]                    a_full;
    logic [35:0]                    b_full;
    logic [34:0]                    s_full;
    logic [WW:0]                    off;
    logic                           off_sub;
    logic [AW:0]                    cen_x, off_x, addr_x;
    logic                           accept, is_push, complete, push_ok, emit;
    logic                           in_last_col, in_last_cell, out_last;
    logic                           up_ok, dn_ok, lf_ok, rt_ok;
    logic [PW-1:0]                  pend_inc, need;
    logic [2:0]                     nb_idx;

    // Clamp registers to their working ranges
    always_comb begin
        gw_x = XW'(grid_width_reg);
        if (gw_x == '0) begin
            eff_w = WW'(1);
        end else if (gw_x > XW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = gw_x[WW-1:0];
        end
        if (grid_height_reg == '0) begin
            eff_h = fdds_pkg::HEIGHT_W'(1);
        end else if (grid_height_reg > fdds_pkg::MAX_HEIGHT) begin
            eff_h = fdds_pkg::MAX_HEIGHT;
        end else begin
            eff_h = grid_height_reg;
        end
        eff_d = (decay_reg > fdds_pkg::ONE_Q16) ? fdds_pkg::ONE_Q16 : decay_reg;
        eff_f = (diffuse_reg > fdds_pkg::ONE_Q16) ? fdds_pkg::ONE_Q16 : diffuse_reg;
        keep  = fdds_pkg::ONE_Q16 - eff_d;
        omf   = fdds_pkg::ONE_Q16 - eff_f;
        w_m1  = eff_w - WW'(1);
        h_m1  = eff_h - fdds_pkg::HEIGHT_W'(1);
    end

    // Window tap address: center plus a row and column offset, wrapped
    always_comb begin
        case (tap_reg)
            4'd1:    begin off = (WW+1)'(eff_w) + (WW+1)'(1); off_sub = 1'b1; end
            4'd2:    begin off = (WW+1)'(eff_w);              off_sub = 1'b1; end
            4'd3:    begin off = (WW+1)'(w_m1);               off_sub = 1'b1; end
            4'd4:    begin off = (WW+1)'(1);                  off_sub = 1'b1; end
            4'd5:    begin off = (WW+1)'(1);                  off_sub = 1'b0; end
            4'd6:    begin off = (WW+1)'(w_m1);               off_sub = 1'b0; end
            4'd7:    begin off = (WW+1)'(eff_w);              off_sub = 1'b0; end
            4'd8:    begin off = (WW+1)'(eff_w) + (WW+1)'(1); off_sub = 1'b0; end
            default: begin off = '0;                          off_sub = 1'b0; end
        endcase
        cen_x = (AW+1)'(cen_ptr_reg);
        off_x = (AW+1)'(off);
        if (off_sub) begin
            addr_x = cen_x - off_x;
            if (cen_x < off_x) begin
                addr_x = addr_x + (AW+1)'(DEPTH);
            end
        end else begin
            addr_x = cen_x + off_x;
            if (addr_x >= (AW+1)'(DEPTH)) begin
                addr_x = addr_x - (AW+1)'(DEPTH);
            end
        end
        rd_addr = addr_x[AW-1:0];
    end

    // Products, each registered before the next step
    assign a_full = 33'(omf) * 33'(v_reg);
    assign b_full = 36'(eff_f) * 36'(sum_reg);
    assign s_full = 35'(keep) * 35'(ab_reg);

    // Handshake and emit decision
    assign s_tready     = (state_reg == fdds_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign accept       = s_tvalid && s_tready;
    assign is_push      = (s_tuser == fdds_pkg::CMD_PUSH);
    assign complete     = (in_row_reg >= eff_h);
    assign in_last_col  = (in_col_reg == w_m1);
    assign in_last_cell = in_last_col && (in_row_reg == h_m1);
    assign out_last     = (out_col_reg == w_m1) && (fdds_pkg::HEIGHT_W'(out_row_reg) == h_m1);
    assign pend_inc     = pend_reg + PW'(1);
    assign need         = PW'(eff_w) + PW'(2);
    assign push_ok      = accept && is_push && !complete;
    assign emit         = (push_ok && ((pend_inc >= need) || in_last_cell))
                        || (accept && !is_push && complete);
    assign mem_we       = push_ok;
    assign up_ok        = (out_row_reg != '0);
    assign dn_ok        = (fdds_pkg::HEIGHT_W'(out_row_reg) != h_m1);
    assign lf_ok        = (out_col_reg != '0);
    assign rt_ok        = (out_col_reg != w_m1);
    assign nb_idx       = 3'(pipe_tap_reg - fdds_pkg::TAP_W'(1));

    // Next state and datapath
    always_comb begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        decay_next       = decay_reg;
        diffuse_next     = diffuse_reg;
        in_col_next      = in_col_reg;
        in_row_next      = in_row_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        pend_next        = pend_reg;
        wr_ptr_next      = wr_ptr_reg;
        out_ptr_next     = out_ptr_reg;
        state_next       = state_reg;
        tap_next         = tap_reg;
        pipe_valid_next  = 1'b0;
        pipe_tap_next    = tap_reg;
        cen_ptr_next     = cen_ptr_reg;
        nb_ok_next       = nb_ok_reg;
        last_next        = last_reg;
        v_next           = v_reg;
        kind_next        = kind_reg;
        sum_next         = sum_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        ab_next          = ab_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Advance the input position on a push
        if (push_ok) begin
            pend_next   = pend_inc;
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (in_last_col) begin
                in_col_next = '0;
                in_row_next = in_row_reg + fdds_pkg::HEIGHT_W'(1);
            end else begin
                in_col_next = in_col_reg + WW'(1);
            end
        end

        // Latch the window of the next result and advance the output position
        if (emit) begin
            pend_next    = is_push ? pend_reg : pend_reg - PW'(1);
            cen_ptr_next = out_ptr_reg;
            nb_ok_next   = {dn_ok & rt_ok, dn_ok, dn_ok & lf_ok, rt_ok,
                            lf_ok, up_ok & rt_ok, up_ok, up_ok & lf_ok};
            last_next    = out_last;
            sum_next     = '0;
            tap_next     = '0;
            state_next   = fdds_pkg::ST_READ;
            if (out_last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                pend_next    = '0;
                wr_ptr_next  = '0;
                out_ptr_next = '0;
            end else begin
                out_ptr_next = (out_ptr_reg == AW'(DEPTH - 1)) ? '0 : out_ptr_reg + AW'(1);
                if (out_col_reg == w_m1) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + fdds_pkg::ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + WW'(1);
                end
            end
        end

        // Collect window data from the registered read port after each read
        if (pipe_valid_reg) begin
            if (pipe_tap_reg == '0) begin
                v_next    = rd_data_reg[fdds_pkg::VALUE_W-1:0];
                kind_next = rd_data_reg[MW-1:fdds_pkg::VALUE_W];
            end else if (nb_ok_reg[nb_idx]) begin
                sum_next = sum_reg + fdds_pkg::SUM_W'(rd_data_reg[fdds_pkg::VALUE_W-1:0]);
            end
        end

        case (state_reg)
            fdds_pkg::ST_IDLE: begin
            end
            fdds_pkg::ST_READ: begin
                pipe_valid_next = 1'b1;
                tap_next        = tap_reg + fdds_pkg::TAP_W'(1);
                if (tap_reg == fdds_pkg::LAST_TAP) begin
                    state_next = fdds_pkg::ST_ACC;
                end
            end
            fdds_pkg::ST_ACC: begin
                state_next = fdds_pkg::ST_MUL;
            end
            fdds_pkg::ST_MUL: begin
                a_next     = a_full[32:16];
                b_next     = b_full[35:19];
                state_next = fdds_pkg::ST_ADD;
            end
            fdds_pkg::ST_ADD: begin
                if (kind_reg == fdds_pkg::KIND_MOVABLE) begin
                    ab_next = (fdds_pkg::PROB_W+1)'(v_reg);
                end else begin
                    ab_next = (fdds_pkg::PROB_W+1)'(a_reg) + (fdds_pkg::PROB_W+1)'(b_reg);
                end
                state_next = fdds_pkg::ST_SCALE;
            end
            fdds_pkg::ST_SCALE: begin
                // Wait for a free output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_last_next  = last_reg;
                    m_data_next  = (kind_reg == fdds_pkg::KIND_IMMOVABLE) ? '0 : s_full[31:16];
                    state_next   = fdds_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fdds_pkg::ST_IDLE;
            end
        endcase

        // Register writes; geometry restarts the grid
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fdds_pkg::CFG_GRID_WIDTH: begin
                    grid_width_next = cfg_data[8:0];
                end
                fdds_pkg::CFG_GRID_HEIGHT: begin
                    grid_height_next = cfg_data[fdds_pkg::HEIGHT_W-1:0];
                end
                fdds_pkg::CFG_DECAY_PROB: begin
                    decay_next = cfg_data;
                end
                fdds_pkg::CFG_DIFFUSE_PROB: begin
                    diffuse_next = cfg_data;
                end
                default: begin
                end
            endcase
            if (cfg_index == fdds_pkg::CFG_GRID_WIDTH || cfg_index == fdds_pkg::CFG_GRID_HEIGHT) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                pend_next    = '0;
                wr_ptr_next  = '0;
                out_ptr_next = '0;
            end
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= {s_tdata[17:16], s_tdata[15:0]};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd16;
            grid_height_reg <= fdds_pkg::HEIGHT_W'(16);
            decay_reg       <= '0;
            diffuse_reg     <= '0;
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            pend_reg        <= '0;
            wr_ptr_reg      <= '0;
            out_ptr_reg     <= '0;
            state_reg       <= fdds_pkg::ST_IDLE;
            tap_reg         <= '0;
            pipe_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            decay_reg       <= decay_next;
            diffuse_reg     <= diffuse_next;
            in_col_reg      <= in_col_next;
            in_row_reg      <= in_row_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            pend_reg        <= pend_next;
            wr_ptr_reg      <= wr_ptr_next;
            out_ptr_reg     <= out_ptr_next;
            state_reg       <= state_next;
            tap_reg         <= tap_next;
            pipe_valid_reg  <= pipe_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pipe_tap_reg <= pipe_tap_next;
        cen_ptr_reg  <= cen_ptr_next;
        nb_ok_reg    <= nb_ok_next;
        last_reg     <= last_next;
        v_reg        <= v_next;
        kind_reg     <= kind_next;
        sum_reg      <= sum_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ab_reg       <= ab_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hw/rtl/fdds_port_checker.sv]
// Port checker of the stencil unit, attached to the top level by bind.
// Depends on fdds_pkg and field_diffusion_decay_stencil_unit_defines.svh.
`timescale 1ns / 1ps
`include "field_diffusion_decay_stencil_unit_defines.svh"

module fdds_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result beat
    `FDDS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Reset empties the output register
    `FDDS_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // Input is only blocked after a beat was taken
    `FDDS_ASSERT_IMP(a_ready_drop, aclk, aresetn, $fell(s_tready), $past(s_tvalid && s_tready))

    // A fresh result follows a taken input beat by RESULT_LATENCY
    `FDDS_ASSERT_IMP(a_latency, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, fdds_pkg::RESULT_LATENCY))

endmodule

bind field_diffusion_decay_stencil_unit fdds_port_checker u_fdds_port_checker (.*);
